@@ hdl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master transaction engine.
`default_nettype none
package i2cm_pkg;
	localparam int ADDR_W = 7;
	localparam int HP_W = 16;

	localparam logic [2:0] MODE_NONE = 3'd0;
	localparam logic [2:0] MODE_WRAW = 3'd1;
	localparam logic [2:0] MODE_RRAW = 3'd2;
	localparam logic [2:0] MODE_WREG = 3'd3;
	localparam logic [2:0] MODE_RREG = 3'd4;
	localparam logic [2:0] MODE_PROBE = 3'd5;

	localparam logic CFG_DEV_ADDR = 1'b0;
	localparam logic CFG_HALF_PERIOD = 1'b1;

	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] reg_addr;
		logic [7:0] length;
		logic [7:0] write_byte;
		logic       write_valid;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       byte_request;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} result_t;
endpackage
`default_nettype wire

@@ hdl/i2cm_front.sv @@
// Input stage: accepts tick beats, sanitizes the mode and queues them.
`default_nettype none
module i2cm_front #(
	parameter int DEPTH = i2cm_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire i2cm_pkg::tick_t  in_tick,
	output logic                  q_valid,
	input  wire logic             q_take,
	output i2cm_pkg::tick_t       q_tick
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	i2cm_pkg::tick_t  slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	i2cm_pkg::tick_t  clean;
	logic             push;
	logic             pop;

	always_comb begin
		clean = in_tick;
		if (!(in_tick.mode inside {[i2cm_pkg::MODE_WRAW : i2cm_pkg::MODE_PROBE]}))
			clean.mode = i2cm_pkg::MODE_NONE;
	end

	assign in_stall = (cnt_q == CW'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_take;
	assign q_tick = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= clean;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule
`default_nettype wire

@@ hdl/i2cm_back.sv @@
// Bus sequencer: runs one queued tick per beat and registers the result.
`default_nettype none
module i2cm_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	output logic                               q_take,
	input  wire i2cm_pkg::tick_t               q_tick,
	input  wire logic [i2cm_pkg::ADDR_W-1:0]   dev_addr,
	input  wire logic [i2cm_pkg::HP_W-1:0]     half_period,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output i2cm_pkg::result_t                  out_res
);
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_START_A = 4'd1;
	localparam logic [3:0] PH_START_B = 4'd2;
	localparam logic [3:0] PH_TX_LOW = 4'd3;
	localparam logic [3:0] PH_TX_HIGH = 4'd4;
	localparam logic [3:0] PH_ACK_LOW = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH = 4'd6;
	localparam logic [3:0] PH_WAIT = 4'd7;
	localparam logic [3:0] PH_RX_LOW = 4'd8;
	localparam logic [3:0] PH_RX_HIGH = 4'd9;
	localparam logic [3:0] PH_MACK_LOW = 4'd10;
	localparam logic [3:0] PH_MACK_HIGH = 4'd11;
	localparam logic [3:0] PH_RSTART = 4'd12;
	localparam logic [3:0] PH_STOP_A = 4'd13;
	localparam logic [3:0] PH_STOP_B = 4'd14;
	localparam logic [3:0] PH_STOP_C = 4'd15;

	localparam logic [1:0] STG_ADDR_W = 2'd0;
	localparam logic [1:0] STG_REG = 2'd1;
	localparam logic [1:0] STG_ADDR_R = 2'd2;
	localparam logic [1:0] STG_DATA = 2'd3;

	logic [3:0]  phase_q, phase_d;
	logic [2:0]  mode_q, mode_d;
	logic [7:0]  reg_q, reg_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bits_q, bits_d;
	logic [15:0] tick_q, tick_d;
	logic        nack_q, nack_d;
	logic [1:0]  stage_q, stage_d;
	logic        step;
	logic        last;
	logic [15:0] hp;
	logic [3:0]  bits_inc;
	logic [7:0]  rx_shift;
	i2cm_pkg::result_t res;

	assign q_take = q_valid && !(out_valid && out_stall);
	assign step = q_take;
	assign hp = (half_period == '0) ? 16'd1 : half_period;
	assign last = ({1'b0, tick_q} + 17'd1 >= {1'b0, hp});
	assign bits_inc = bits_q + 4'd1;
	assign rx_shift = {shift_q[6:0], q_tick.sda_in};

	always_comb begin
		phase_d = phase_q;
		mode_d = mode_q;
		reg_d = reg_q;
		left_d = left_q;
		shift_d = shift_q;
		bits_d = bits_q;
		tick_d = tick_q;
		nack_d = nack_q;
		stage_d = stage_q;
		res = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;
		res.busy_res = (phase_q != PH_IDLE);

		case (phase_q)
			PH_START_B: res.sda_level = 1'b0;
			PH_TX_LOW: begin
				res.scl_level = 1'b0;
				res.sda_level = shift_q[7];
			end
			PH_TX_HIGH: res.sda_level = shift_q[7];
			PH_ACK_LOW, PH_RX_LOW, PH_RSTART: res.scl_level = 1'b0;
			PH_WAIT: begin
				res.scl_level = 1'b0;
				res.byte_request = 1'b1;
			end
			PH_MACK_LOW: begin
				res.scl_level = 1'b0;
				res.sda_level = (left_q == '0);
			end
			PH_MACK_HIGH: res.sda_level = (left_q == '0);
			PH_STOP_A: begin
				res.scl_level = 1'b0;
				res.sda_level = 1'b0;
			end
			PH_STOP_B: res.sda_level = 1'b0;
			default: ;
		endcase

		if (phase_q != PH_IDLE && phase_q != PH_WAIT && !last) begin
			tick_d = tick_q + 16'd1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (q_tick.mode != i2cm_pkg::MODE_NONE) begin
						mode_d = q_tick.mode;
						reg_d = q_tick.reg_addr;
						left_d = q_tick.length;
						if ((q_tick.mode == i2cm_pkg::MODE_RRAW ||
							q_tick.mode == i2cm_pkg::MODE_RREG) && q_tick.length == '0)
							left_d = 8'd1;
						nack_d = 1'b0;
						if (q_tick.mode == i2cm_pkg::MODE_RRAW ||
							q_tick.mode == i2cm_pkg::MODE_PROBE) begin
							stage_d = STG_ADDR_R;
							shift_d = {dev_addr, 1'b1};
						end else begin
							stage_d = STG_ADDR_W;
							shift_d = {dev_addr, 1'b0};
						end
						bits_d = '0;
						phase_d = PH_START_A;
						tick_d = '0;
					end
				end
				PH_START_A: begin
					phase_d = PH_START_B;
					tick_d = '0;
				end
				PH_START_B: begin
					bits_d = '0;
					phase_d = PH_TX_LOW;
					tick_d = '0;
				end
				PH_TX_LOW: begin
					phase_d = PH_TX_HIGH;
					tick_d = '0;
				end
				PH_TX_HIGH: begin
					shift_d = {shift_q[6:0], 1'b0};
					bits_d = bits_inc;
					phase_d = (bits_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
					tick_d = '0;
				end
				PH_ACK_LOW: begin
					phase_d = PH_ACK_HIGH;
					tick_d = '0;
				end
				PH_ACK_HIGH: begin
					tick_d = '0;
					if (q_tick.sda_in) begin
						nack_d = 1'b1;
						phase_d = PH_STOP_A;
					end else if (stage_q == STG_ADDR_W &&
						(mode_q == i2cm_pkg::MODE_WREG || mode_q == i2cm_pkg::MODE_RREG)) begin
						stage_d = STG_REG;
						shift_d = reg_q;
						bits_d = '0;
						phase_d = PH_TX_LOW;
					end else if (stage_q == STG_REG && mode_q == i2cm_pkg::MODE_RREG) begin
						stage_d = STG_ADDR_R;
						phase_d = PH_RSTART;
					end else if (stage_q == STG_ADDR_R) begin
						if (mode_q == i2cm_pkg::MODE_PROBE) begin
							phase_d = PH_STOP_A;
						end else begin
							shift_d = '0;
							bits_d = '0;
							phase_d = PH_RX_LOW;
						end
					end else if (left_q == '0) begin
						phase_d = PH_STOP_A;
					end else begin
						stage_d = STG_DATA;
						phase_d = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (q_tick.write_valid) begin
						left_d = left_q - 8'd1;
						shift_d = q_tick.write_byte;
						bits_d = '0;
						phase_d = PH_TX_LOW;
						tick_d = '0;
					end
				end
				PH_RSTART: begin
					shift_d = {dev_addr, 1'b1};
					bits_d = '0;
					phase_d = PH_START_A;
					tick_d = '0;
				end
				PH_RX_LOW: begin
					phase_d = PH_RX_HIGH;
					tick_d = '0;
				end
				PH_RX_HIGH: begin
					shift_d = rx_shift;
					bits_d = bits_inc;
					tick_d = '0;
					if (bits_inc >= 4'd8) begin
						res.read_valid = 1'b1;
						res.read_byte = rx_shift;
						left_d = left_q - 8'd1;
						phase_d = PH_MACK_LOW;
					end else begin
						phase_d = PH_RX_LOW;
					end
				end
				PH_MACK_LOW: begin
					phase_d = PH_MACK_HIGH;
					tick_d = '0;
				end
				PH_MACK_HIGH: begin
					tick_d = '0;
					if (left_q == '0) begin
						phase_d = PH_STOP_A;
					end else begin
						shift_d = '0;
						bits_d = '0;
						phase_d = PH_RX_LOW;
					end
				end
				PH_STOP_A: begin
					phase_d = PH_STOP_B;
					tick_d = '0;
				end
				PH_STOP_B: begin
					phase_d = PH_STOP_C;
					tick_d = '0;
				end
				PH_STOP_C: begin
					res.done_res = 1'b1;
					res.status = nack_q;
					phase_d = PH_IDLE;
					tick_d = '0;
				end
				default: begin
					phase_d = PH_IDLE;
					tick_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q <= '0;
			reg_q <= '0;
			left_q <= '0;
			shift_q <= '0;
			bits_q <= '0;
			tick_q <= '0;
			nack_q <= 1'b0;
			stage_q <= STG_ADDR_W;
			out_valid <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				mode_q <= mode_d;
				reg_q <= reg_d;
				left_q <= left_d;
				shift_q <= shift_d;
				bits_q <= bits_d;
				tick_q <= tick_d;
				nack_q <= nack_d;
				stage_q <= stage_d;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_res <= res;
	end
endmodule
`default_nettype wire

@@ hdl/i2c_master_transaction_engine.sv @@
// Top level of the I2C master transaction engine.
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | mode reg_addr length write_byte write_valid sda_in
//  out      | out_valid/out_stall| scl_level sda_level read_byte read_valid ... status
//  cfg      | cfg_valid/cfg_ready| cfg_index cfg_data
// One tick beat per clock unless stalled; each result is registered as its tick runs.
// A two-entry queue separates input from the sequencer; the output register holds
// under out_stall while the queue keeps filling.
// Reset clears the sequencer to idle, address 0, half period 1.
`default_nettype none
module i2c_master_transaction_engine #(
	parameter int QDEPTH = i2cm_pkg::FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] reg_addr,
	input  wire logic [7:0] length,
	input  wire logic [7:0] write_byte,
	input  wire logic       write_valid,
	input  wire logic       sda_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            scl_level,
	output logic            sda_level,
	output logic [7:0]      read_byte,
	output logic            read_valid,
	output logic            byte_request,
	output logic            busy_res,
	output logic            done_res,
	output logic            status,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [15:0] cfg_data
);
	i2cm_pkg::tick_t   in_tick;
	i2cm_pkg::tick_t   q_tick;
	i2cm_pkg::result_t res;
	logic q_valid, q_take;
	logic [i2cm_pkg::ADDR_W-1:0] dev_q;
	logic [i2cm_pkg::HP_W-1:0]   hp_q;

	assign in_tick = '{mode: mode, reg_addr: reg_addr, length: length,
		write_byte: write_byte, write_valid: write_valid, sda_in: sda_in};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
			hp_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cm_pkg::CFG_DEV_ADDR: dev_q <= cfg_data[i2cm_pkg::ADDR_W-1:0];
				i2cm_pkg::CFG_HALF_PERIOD: hp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cm_front #(.DEPTH(QDEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_tick(in_tick), .q_valid(q_valid), .q_take(q_take), .q_tick(q_tick)
	);

	i2cm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_tick(q_tick), .dev_addr(dev_q), .half_period(hp_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	assign scl_level = res.scl_level;
	assign sda_level = res.sda_level;
	assign read_byte = res.read_byte;
	assign read_valid = res.read_valid;
	assign byte_request = res.byte_request;
	assign busy_res = res.busy_res;
	assign done_res = res.done_res;
	assign status = res.status;

`ifndef NO_ASSERTIONS
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> done_res) else $error("status without done");
	a_read_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> scl_level) else $error("read off SCL high");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res) else $error("done while idle");
`endif
endmodule
`default_nettype wire

@@ dv/i2cm_checker.sv @@
// Checker for the I2C master engine: watches all channels, predicts each result beat and compares.
module i2cm_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] reg_addr,
	input  wire logic [7:0] length,
	input  wire logic [7:0] write_byte,
	input  wire logic       write_valid,
	input  wire logic       sda_in,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       scl_level,
	input  wire logic       sda_level,
	input  wire logic [7:0] read_byte,
	input  wire logic       read_valid,
	input  wire logic       byte_request,
	input  wire logic       busy_res,
	input  wire logic       done_res,
	input  wire logic       status,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [15:0] cfg_data,
	output int              fails,
	output int              pending
);
	typedef enum logic [4:0] {
		S_IDLE, S_START_A, S_START_B, S_TX_LOW, S_TX_HIGH, S_ACK_LOW, S_ACK_HIGH, S_WAIT,
		S_RX_LOW, S_RX_HIGH, S_MACK_LOW, S_MACK_HIGH, S_RSTART, S_STOP_A, S_STOP_B, S_STOP_C
	} bus_phase_t;
	typedef enum logic [1:0] {B_ADDR_W, B_REG, B_ADDR_R, B_DATA} byte_stage_t;

	logic [6:0]  dev_addr;
	logic [15:0] half_period;
	bus_phase_t  ph;
	byte_stage_t stg;
	logic [2:0]  cur_mode;
	logic [7:0]  saved_reg, remaining, shreg;
	logic [3:0]  nbits;
	logic [15:0] ticks;
	logic        nacked;
	i2cm_pkg::result_t bus_results[$];

	task automatic enter(input bus_phase_t p);
		ph = p;
		ticks = '0;
	endtask

	task automatic load_tx(input logic [7:0] b);
		shreg = b;
		nbits = '0;
		enter(S_TX_LOW);
	endtask

	task automatic write_acked();
		if (remaining == 0) begin
			enter(S_STOP_A);
		end else begin
			stg = B_DATA;
			enter(S_WAIT);
		end
	endtask

	task automatic bus_tick(input i2cm_pkg::tick_t t, output i2cm_pkg::result_t r);
		int hp;
		r = '0;
		r.scl_level = 1'b1;
		r.sda_level = 1'b1;
		r.busy_res = (ph != S_IDLE);
		hp = (half_period == 0) ? 1 : int'(half_period);
		case (ph)
			S_START_B: r.sda_level = 1'b0;
			S_TX_LOW: begin
				r.scl_level = 1'b0;
				r.sda_level = shreg[7];
			end
			S_TX_HIGH: r.sda_level = shreg[7];
			S_ACK_LOW, S_RX_LOW, S_RSTART: r.scl_level = 1'b0;
			S_WAIT: begin
				r.scl_level = 1'b0;
				r.byte_request = 1'b1;
			end
			S_MACK_LOW: begin
				r.scl_level = 1'b0;
				r.sda_level = (remaining == 0);
			end
			S_MACK_HIGH: r.sda_level = (remaining == 0);
			S_STOP_A: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b0;
			end
			S_STOP_B: r.sda_level = 1'b0;
			default: ;
		endcase
		if (ph != S_IDLE && ph != S_WAIT && int'(ticks) + 1 < hp) begin
			ticks = ticks + 1'b1;
		end else begin
			case (ph)
				S_IDLE: if (t.mode >= i2cm_pkg::MODE_WRAW && t.mode <= i2cm_pkg::MODE_PROBE) begin
					cur_mode = t.mode;
					saved_reg = t.reg_addr;
					remaining = t.length;
					if ((t.mode == i2cm_pkg::MODE_RRAW || t.mode == i2cm_pkg::MODE_RREG) &&
						t.length == 0)
						remaining = 8'd1;
					nacked = 1'b0;
					if (t.mode == i2cm_pkg::MODE_RRAW || t.mode == i2cm_pkg::MODE_PROBE) begin
						stg = B_ADDR_R;
						shreg = {dev_addr, 1'b1};
					end else begin
						stg = B_ADDR_W;
						shreg = {dev_addr, 1'b0};
					end
					nbits = '0;
					enter(S_START_A);
				end
				S_START_A: enter(S_START_B);
				S_START_B: load_tx(shreg);
				S_TX_LOW: enter(S_TX_HIGH);
				S_TX_HIGH: begin
					shreg = shreg << 1;
					nbits = nbits + 1'b1;
					enter(nbits >= 8 ? S_ACK_LOW : S_TX_LOW);
				end
				S_ACK_LOW: enter(S_ACK_HIGH);
				S_ACK_HIGH: begin
					if (t.sda_in) begin
						nacked = 1'b1;
						enter(S_STOP_A);
					end else if (stg == B_ADDR_W) begin
						if (cur_mode == i2cm_pkg::MODE_WREG || cur_mode == i2cm_pkg::MODE_RREG) begin
							stg = B_REG;
							load_tx(saved_reg);
						end else begin
							write_acked();
						end
					end else if (stg == B_REG) begin
						if (cur_mode == i2cm_pkg::MODE_RREG) begin
							stg = B_ADDR_R;
							enter(S_RSTART);
						end else begin
							write_acked();
						end
					end else if (stg == B_ADDR_R) begin
						if (cur_mode == i2cm_pkg::MODE_PROBE) begin
							enter(S_STOP_A);
						end else begin
							shreg = '0;
							nbits = '0;
							enter(S_RX_LOW);
						end
					end else begin
						write_acked();
					end
				end
				S_WAIT: if (t.write_valid) begin
					remaining = remaining - 1'b1;
					load_tx(t.write_byte);
				end
				S_RSTART: begin
					shreg = {dev_addr, 1'b1};
					nbits = '0;
					enter(S_START_A);
				end
				S_RX_LOW: enter(S_RX_HIGH);
				S_RX_HIGH: begin
					shreg = {shreg[6:0], t.sda_in};
					nbits = nbits + 1'b1;
					if (nbits >= 8) begin
						r.read_valid = 1'b1;
						r.read_byte = shreg;
						remaining = remaining - 1'b1;
						enter(S_MACK_LOW);
					end else begin
						enter(S_RX_LOW);
					end
				end
				S_MACK_LOW: enter(S_MACK_HIGH);
				S_MACK_HIGH: begin
					if (remaining == 0) begin
						enter(S_STOP_A);
					end else begin
						shreg = '0;
						nbits = '0;
						enter(S_RX_LOW);
					end
				end
				S_STOP_A: enter(S_STOP_B);
				S_STOP_B: enter(S_STOP_C);
				S_STOP_C: begin
					r.done_res = 1'b1;
					r.status = nacked;
					enter(S_IDLE);
				end
				default: enter(S_IDLE);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		i2cm_pkg::result_t got, want;
		i2cm_pkg::tick_t t;
		if (!arst_n) begin
			dev_addr <= '0;
			half_period <= 16'd1;
			ph = S_IDLE;
			stg = B_ADDR_W;
			cur_mode = '0;
			saved_reg = '0;
			remaining = '0;
			shreg = '0;
			nbits = '0;
			ticks = '0;
			nacked = 1'b0;
			bus_results.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{scl_level, sda_level, read_byte, read_valid, byte_request,
					busy_res, done_res, status};
				if (bus_results.size() == 0) begin
					fails <= fails + 1;
					if (fails < 10)
						$display("unexpected result beat %p", got);
				end else begin
					want = bus_results.pop_front();
					if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
						got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
						got.byte_request !== want.byte_request ||
						got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
						got.status !== want.status) begin
						fails <= fails + 1;
						if (fails < 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == i2cm_pkg::CFG_DEV_ADDR)
					dev_addr <= cfg_data[6:0];
				else
					half_period <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				t = '{mode, reg_addr, length, write_byte, write_valid, sda_in};
				bus_tick(t, want);
				bus_results.push_back(want);
			end
			pending <= bus_results.size();
		end
	end
endmodule

@@ dv/tb.sv @@
// Testbench top for the I2C master engine: clock, reset, stimulus, back-pressure and verdict.
module tb;
	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [2:0]  mode;
	logic [7:0]  reg_addr, length, write_byte, read_byte;
	logic        write_valid, sda_in;
	logic        scl_level, sda_level, read_valid, byte_request, busy_res, done_res, status;
	logic        cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;
	int          fails, pending;
	int          send_idle_pct, stall_pct, cycles;
	logic        hold_on;

	i2c_master_transaction_engine i_dut (.*);
	i2cm_checker i_chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send(input logic [2:0] m, input logic [7:0] ra, input logic [7:0] len,
		input logic [7:0] wb, input logic wv, input logic sd);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		reg_addr <= ra;
		length <= len;
		write_byte <= wb;
		write_valid <= wv;
		sda_in <= sd;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random();
		logic [2:0] m;
		logic [7:0] len;
		logic       sd;
		m = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7)) : i2cm_pkg::MODE_NONE;
		len = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
		sd = ($urandom_range(0, 2) == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
		send(m, 8'($urandom), len, 8'($urandom), 1'($urandom_range(0, 1)), sd);
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		hold_on = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid = 1'b0;
		mode = i2cm_pkg::MODE_NONE;
		reg_addr = '0;
		length = '0;
		write_byte = '0;
		write_valid = 1'b0;
		sda_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = i2cm_pkg::CFG_DEV_ADDR;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'hffff);
		write_reg(i2cm_pkg::CFG_DEV_ADDR, 16'h007f);
		send(i2cm_pkg::MODE_WRAW, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0);
		repeat (4) send(i2cm_pkg::MODE_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		drain();
		write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'h0000);
		send(i2cm_pkg::MODE_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		send(3'd7, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
		send(3'd6, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		for (int m = i2cm_pkg::MODE_WRAW; m <= i2cm_pkg::MODE_PROBE; m++) begin
			send(3'(m), 8'ha5, 8'h00, 8'h5a, 1'b1, 1'b0);
			repeat (3) send(i2cm_pkg::MODE_NONE, 8'h00, 8'h00, 8'hff, 1'b1, 1'b0);
		end
		repeat (80) send(i2cm_pkg::MODE_NONE, 8'h00, 8'h00, 8'hc3, 1'b1,
			1'($urandom_range(0, 1)));

		for (int p = 0; p < 3; p++) begin
			drain();
			send_idle_pct = (p == 0) ? 37 : (p == 1) ? 87 : 0;
			stall_pct = (p == 0) ? 87 : (p == 1) ? 37 : 0;
			write_reg(i2cm_pkg::CFG_DEV_ADDR,
				(p == 0) ? 16'h0000 : 16'($urandom_range(0, 127)));
			write_reg(i2cm_pkg::CFG_HALF_PERIOD,
				(p == 2) ? 16'd1 : 16'($urandom_range(1, 3)));
			if (p == 2)
				hold_on <= 1'b1;
			for (int i = 0; i < 128; i++) begin
				if (p == 2 && i == 64) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end
				send_random();
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		wait (hold_on);
		repeat (60) @(posedge clk);
		hold_on <= 1'b0;
	end
endmodule

@@ sim.f @@
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_transaction_engine.sv
dv/i2cm_checker.sv
dv/tb.sv
